// ----- rtl/assert_macros.svh -----
// Shared assertion macros for the matcher checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/sam_pkg.sv -----
// ----------------------------------------------------------------------------
// sam_pkg
// Types and codes shared by the sliding-window anagram matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sam_pkg;

   localparam int LETTER_BITS = 5;
   localparam int ACTION_BITS = 2;

   localparam logic [ACTION_BITS-1:0] ACT_BEGIN = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_LOAD  = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_SCAN  = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_RSVD  = 2'd3;

   // One accepted step as seen by the delay line.
   typedef struct packed {
      logic                   clear;
      logic                   load;
      logic                   scan;
      logic [LETTER_BITS-1:0] letter;
   } step_type;

   // Controls into the balance counter row.
   typedef struct packed {
      logic                   clear;
      logic                   load;
      logic                   scan;
      logic                   leave_en;
      logic [LETTER_BITS-1:0] enter_letter;
      logic [LETTER_BITS-1:0] leave_letter;
   } cell_ctrl_type;

   // Class crossings reported by the balance counter row.
   typedef struct packed {
      logic new_class;   // load hit a class whose balance was zero
      logic gain;        // scan drove a class balance from one to zero
      logic loss;        // scan drove a class balance from zero to one
   } cell_status_type;

endpackage

// ----- rtl/sam_delay_line.sv -----
// ----------------------------------------------------------------------------
// sam_delay_line
// Circular letter store holding the recent text; prefetches the letter that
// leaves the window on the next scan item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sam_delay_line #(
   parameter int MAX_PATTERN = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sam_pkg::step_type                 step,
   output logic [sam_pkg::LETTER_BITS-1:0]   leave_letter
);

   localparam int PTR_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(MAX_PATTERN - 1);

   logic [sam_pkg::LETTER_BITS-1:0] mem [MAX_PATTERN];
   logic [PTR_BITS-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [sam_pkg::LETTER_BITS-1:0] rd_data_ff;

   // rd_ptr trails wr_ptr by the pattern length, modulo the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (step.clear) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
      end else if (step.load) begin
         rd_ptr_in = (rd_ptr_ff == '0) ? PTR_LAST : rd_ptr_ff - 1'b1;
      end else if (step.scan) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Read for the next item; forward the letter written in this cycle.
   always_ff @(posedge clock) begin
      if (step.scan) begin
         mem[wr_ptr_ff] <= step.letter;
      end
      if (step.scan && (rd_ptr_in == wr_ptr_ff)) begin
         rd_data_ff <= step.letter;
      end else begin
         rd_data_ff <= mem[rd_ptr_in];
      end
   end

   assign leave_letter = rd_data_ff;

endmodule

// ----- rtl/sam_balance_cells.sv -----
// ----------------------------------------------------------------------------
// sam_balance_cells
// One signed balance counter per letter class, with class crossing flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sam_balance_cells #(
   parameter int ALPHABET_SIZE = 26,
   parameter int MAX_PATTERN   = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sam_pkg::cell_ctrl_type   ctrl,
   output sam_pkg::cell_status_type status
);

   // balance ranges over -MAX_PATTERN .. MAX_PATTERN
   localparam int BAL_BITS = $clog2(MAX_PATTERN + 1) + 1;
   localparam logic signed [BAL_BITS-1:0] BAL_ONE = BAL_BITS'(1);

   logic signed [BAL_BITS-1:0] bal_ff [ALPHABET_SIZE];
   logic signed [BAL_BITS-1:0] bal_in [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0]   enter_hit;
   logic [ALPHABET_SIZE-1:0]   leave_hit;

   always_comb begin
      status = '0;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         enter_hit[i] = (int'(ctrl.enter_letter) == i);
         leave_hit[i] = ctrl.leave_en && (int'(ctrl.leave_letter) == i);
         bal_in[i]    = bal_ff[i];
         if (ctrl.clear) begin
            bal_in[i] = '0;
         end else if (ctrl.load) begin
            if (enter_hit[i]) begin
               bal_in[i] = bal_ff[i] + BAL_ONE;
               if (bal_ff[i] == '0) status.new_class = 1'b1;
            end
         end else if (ctrl.scan) begin
            // same letter entering and leaving cancels out
            if (enter_hit[i] && !leave_hit[i]) begin
               bal_in[i] = bal_ff[i] - BAL_ONE;
               if (bal_ff[i] == BAL_ONE) status.gain = 1'b1;
            end else if (leave_hit[i] && !enter_hit[i]) begin
               bal_in[i] = bal_ff[i] + BAL_ONE;
               if (bal_ff[i] == '0) status.loss = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALPHABET_SIZE; i++) bal_ff[i] <= '0;
      end else begin
         for (int i = 0; i < ALPHABET_SIZE; i++) bal_ff[i] <= bal_in[i];
      end
   end

endmodule

// ----- rtl/sliding_anagram_matcher.sv -----
// ----------------------------------------------------------------------------
// sliding_anagram_matcher
// Sliding-window anagram search over a stream of letters.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser carries the action (begin, load, scan), tdata the
//   letter. A begin item clears the search; load items add pattern letters;
//   each scan item checks whether the last pattern-length letters form an
//   anagram of the pattern.
//   rsp channel: one item per valid scan item. tuser is the match flag,
//   tdata the start position of the matching window (zero when no match,
//   saturating at all ones).
//   Path: a scan item is taken into the input register, then passes once
//   through the counters into the result register; a stalled rsp side can
//   hold it in the input register in between.
//   Throughput: one item per cycle while the rsp side is not stalled; the
//   leaving letter is prefetched from the delay line memory ahead of its item.
//   Reset: clears all counters and both channel registers; the letter store
//   needs no clearing. A stalled rsp side holds its item while one more req
//   item waits in the input register, then req_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_anagram_matcher #(
   parameter int MAX_PATTERN   = 64,
   parameter int ALPHABET_SIZE = 26,
   parameter int POSITION_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // letter[4:0]
   input  logic [1:0]                            req_tuser,   // action[1:0]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((POSITION_BITS+7)/8)*8-1:0]    rsp_tdata,   // start_position
   output logic [0:0]                            rsp_tuser    // match
);

   localparam int RSP_DATA_BITS = ((POSITION_BITS + 7) / 8) * 8;
   localparam int LEN_BITS      = $clog2(MAX_PATTERN + 1);
   localparam int CLASS_BITS    = $clog2(ALPHABET_SIZE + 1);
   localparam int WIDE_BITS     = POSITION_BITS + LEN_BITS;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [LEN_BITS-1:0]      LEN_MAX = LEN_BITS'(MAX_PATTERN);

   // input register
   logic                                  in_valid_ff;
   logic [sam_pkg::ACTION_BITS-1:0]       in_action_ff;
   logic [sam_pkg::LETTER_BITS-1:0]       in_letter_ff;

   // search state
   logic [LEN_BITS-1:0]      len_ff, len_in;
   logic [LEN_BITS-1:0]      fill_ff, fill_in;
   logic [CLASS_BITS-1:0]    needed_ff, needed_in;
   logic [CLASS_BITS-1:0]    satisfied_ff, satisfied_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     started_ff, started_in;

   // result register
   logic                     rsp_valid_ff;
   logic                     rsp_match_ff, rsp_match_in;
   logic [POSITION_BITS-1:0] rsp_start_ff, rsp_start_in;

   logic                              advance;
   logic                              letter_ok;
   logic                              do_clear, do_load, do_scan;
   logic [sam_pkg::LETTER_BITS-1:0]   delayed_letter;
   logic [WIDE_BITS-1:0]              pos_wide, len_wide;
   sam_pkg::step_type                 step;
   sam_pkg::cell_ctrl_type            cell_ctrl;
   sam_pkg::cell_status_type          cell_status;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign letter_ok  = (int'(in_letter_ff) < ALPHABET_SIZE);

   always_comb begin
      do_clear = 1'b0;
      do_load  = 1'b0;
      do_scan  = 1'b0;
      unique case (in_action_ff)
         sam_pkg::ACT_BEGIN: do_clear = advance;
         sam_pkg::ACT_LOAD:  do_load  = advance && letter_ok && !started_ff &&
                                        (len_ff < LEN_MAX);
         sam_pkg::ACT_SCAN:  do_scan  = advance && letter_ok;
         sam_pkg::ACT_RSVD:  ;
         default:            ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_action_ff <= req_tuser;
         in_letter_ff <= req_tdata[sam_pkg::LETTER_BITS-1:0];
      end
   end

   assign step.clear  = do_clear;
   assign step.load   = do_load;
   assign step.scan   = do_scan;
   assign step.letter = in_letter_ff;

   sam_delay_line #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_delay (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .leave_letter (delayed_letter)
   );

   // with an empty pattern the arriving letter leaves at once
   assign cell_ctrl.clear        = do_clear;
   assign cell_ctrl.load         = do_load;
   assign cell_ctrl.scan         = do_scan;
   assign cell_ctrl.leave_en     = do_scan && (fill_ff >= len_ff);
   assign cell_ctrl.enter_letter = in_letter_ff;
   assign cell_ctrl.leave_letter = (len_ff == '0) ? in_letter_ff : delayed_letter;

   sam_balance_cells #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .MAX_PATTERN   (MAX_PATTERN)
   ) u_cells (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (cell_ctrl),
      .status (cell_status)
   );

   always_comb begin
      len_in       = len_ff;
      fill_in      = fill_ff;
      needed_in    = needed_ff;
      satisfied_in = satisfied_ff;
      pos_in       = pos_ff;
      started_in   = started_ff;
      if (do_clear) begin
         len_in       = '0;
         fill_in      = '0;
         needed_in    = '0;
         satisfied_in = '0;
         pos_in       = '0;
         started_in   = 1'b0;
      end else if (do_load) begin
         len_in    = len_ff + 1'b1;
         needed_in = needed_ff + CLASS_BITS'(cell_status.new_class);
      end else if (do_scan) begin
         started_in   = 1'b1;
         satisfied_in = satisfied_ff + CLASS_BITS'(cell_status.gain)
                        - CLASS_BITS'(cell_status.loss);
         if (fill_ff < len_ff) fill_in = fill_ff + 1'b1;
         if (pos_ff != POS_MAX) pos_in = pos_ff + 1'b1;
      end
   end

   assign pos_wide = WIDE_BITS'(pos_in);
   assign len_wide = WIDE_BITS'(len_ff);

   always_comb begin
      rsp_match_in = (len_ff != '0) && (satisfied_in == needed_ff);
      rsp_start_in = '0;
      if (rsp_match_in) begin
         if (pos_in == POS_MAX) begin
            rsp_start_in = POS_MAX;
         end else if (pos_wide >= len_wide) begin
            rsp_start_in = POSITION_BITS'(pos_wide - len_wide);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         fill_ff      <= '0;
         needed_ff    <= '0;
         satisfied_ff <= '0;
         pos_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         needed_ff    <= needed_in;
         satisfied_ff <= satisfied_in;
         pos_ff       <= pos_in;
         started_ff   <= started_in;
         if (do_scan) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_scan) begin
         rsp_match_ff <= rsp_match_in;
         rsp_start_ff <= rsp_start_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_start_ff);
   assign rsp_tuser  = rsp_match_ff;

endmodule

// ----- rtl/sam_checker.sv -----
// ----------------------------------------------------------------------------
// sam_checker
// Port-level checks for the anagram matcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sam_checker #(
   parameter int RSP_DATA_BITS = 32
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [0:0]               rsp_tuser
);

   // a held result keeps its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a window that does not match reports start zero
   `ASSERT_IMPLIES(a_nomatch_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0)

   // input side only backs up behind a pending result
   `ASSERT_IMPLIES(a_stall_cause, clock, reset, !req_tready, rsp_tvalid && !rsp_tready)

   // reset empties the result register
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind sliding_anagram_matcher sam_checker #(
   .RSP_DATA_BITS (RSP_DATA_BITS)
) u_sam_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- tb/tb_sliding_anagram_matcher.sv -----
// ----------------------------------------------------------------------------
// tb_sliding_anagram_matcher
// Self-checking bench for the sliding-window anagram matcher. A short table
// of items with hand-fixed verdicts covers the corners, then random searches
// (begin, a pattern, text rich in anagrams, some junk) run under random
// back-pressure on both channels (none at the end); a behavioral model checks them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sliding_anagram_matcher;

   localparam int  MAX_PAT      = 64;
   localparam int  ALPHA        = 26;
   localparam int  TARGET_ITEMS = 1400;
   localparam int  QUIET_LIMIT  = 2000;
   localparam longint POS_MAX   = 64'hFFFF_FFFF;

   typedef struct packed {
      logic        match;
      logic [31:0] start;
   } verdict_type;

   typedef struct packed {
      logic [sam_pkg::ACTION_BITS-1:0] act;
      logic [sam_pkg::LETTER_BITS-1:0] letter;
      logic                            typed;     // verdict below is fixed by hand
      verdict_type                     verdict;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;              // letter[4:0]
   logic [1:0]  req_tuser = sam_pkg::ACT_BEGIN; // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;                     // start_position[31:0]
   logic [0:0]  rsp_tuser;                     // match

   sliding_anagram_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // model state
   int             balance [ALPHA];
   logic [4:0]     recent [MAX_PAT];
   int             pat_len, needed, satisfied, fill, wptr;
   longint         text_pos;
   bit             scanning;

   verdict_type    window_verdicts[$];
   int             effective_items = 0;
   int             errors = 0;
   int             src_idle_pct = 21;
   int             snk_idle_pct = 83;
   int             quiet = 0;

   function automatic void clear_search();
      foreach (balance[i]) balance[i] = 0;
      foreach (recent[i]) recent[i] = '0;
      pat_len   = 0;
      needed    = 0;
      satisfied = 0;
      fill      = 0;
      wptr      = 0;
      text_pos  = 0;
      scanning  = 1'b0;
   endfunction

   function automatic void advance_window(input logic [1:0] act, input logic [4:0] ltr,
                                          output bit produced, output verdict_type v,
                                          output bit effective);
      int     leaving;
      longint first;
      produced  = 1'b0;
      v         = '0;
      effective = 1'b0;
      if (act == sam_pkg::ACT_BEGIN) begin
         clear_search();
         effective = 1'b1;
         return;
      end
      if (act == sam_pkg::ACT_RSVD || ltr >= ALPHA) return;
      if (act == sam_pkg::ACT_LOAD) begin
         if (scanning || pat_len >= MAX_PAT) return;
         if (balance[ltr] == 0) needed++;
         balance[ltr]++;
         pat_len++;
         effective = 1'b1;
         return;
      end
      scanning = 1'b1;
      balance[ltr]--;
      if (balance[ltr] == 0) satisfied++;
      if (fill < pat_len) begin
         fill++;
      end else begin
         // empty pattern: the letter leaves as soon as it enters
         leaving = (pat_len == 0) ? int'(ltr)
                                  : int'(recent[(wptr + MAX_PAT - pat_len) % MAX_PAT]);
         balance[leaving]++;
         if (balance[leaving] == 1) satisfied--;
      end
      recent[wptr] = ltr;
      wptr = (wptr + 1) % MAX_PAT;
      if (text_pos < POS_MAX) text_pos++;
      produced  = 1'b1;
      effective = 1'b1;
      if (pat_len > 0 && satisfied == needed) begin
         if (text_pos >= POS_MAX) first = POS_MAX;
         else if (text_pos >= pat_len) first = text_pos - pat_len;
         else first = 0;
         v.match = 1'b1;
         v.start = first[31:0];
      end
   endfunction

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   // Drive one item and hold it until accepted; valid stays up on return.
   task automatic send_req(input logic [1:0] act, input logic [4:0] ltr,
                           input bit typed, input verdict_type typed_v);
      bit          produced;
      bit          effective;
      verdict_type v;
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {3'b000, ltr};
      do @(posedge clock); while (!req_tready);
      advance_window(act, ltr, produced, v, effective);
      if (produced) window_verdicts.insert(window_verdicts.size(), typed ? typed_v : v);
      if (effective) effective_items++;
   endtask

   task automatic send_noise();
      case ($urandom_range(2))
         0: send_req(sam_pkg::ACT_RSVD, 5'($urandom_range(31)), 1'b0, '0);
         1: send_req(sam_pkg::ACT_LOAD, 5'($urandom_range(31, ALPHA)), 1'b0, '0);
         default: send_req(sam_pkg::ACT_SCAN, 5'($urandom_range(31, ALPHA)), 1'b0, '0);
      endcase
   endtask

   function automatic logic [4:0] pick_letter(input logic [4:0] pal[4], input int npal);
      if (npal == 0) return 5'($urandom_range(ALPHA - 1));
      return pal[$urandom_range(npal - 1)];
   endfunction

   // One search: begin, pattern, then text drawn from the pattern's palette
   // with whole permutations of the pattern dropped in.
   task automatic run_search();
      int         plen, nscan, npal, k, j, r, loaded;
      logic [4:0] palette[4];
      logic [4:0] pat[MAX_PAT];
      logic [4:0] ltr, tmp;
      send_req(sam_pkg::ACT_BEGIN, 5'($urandom_range(31)), 1'b0, '0);
      r = $urandom_range(19);
      if (r == 0) plen = 0;
      else if (r < 3) plen = $urandom_range(70, 60);   // runs past a full pattern
      else plen = $urandom_range(8, 1);
      npal = ($urandom_range(5) == 0) ? 0 : $urandom_range(4, 1);
      for (k = 0; k < 4; k++) palette[k] = 5'($urandom_range(ALPHA - 1));
      loaded = 0;
      for (k = 0; k < plen; k++) begin
         if ($urandom_range(24) == 0) send_noise();
         ltr = pick_letter(palette, npal);
         send_req(sam_pkg::ACT_LOAD, ltr, 1'b0, '0);
         if (loaded < MAX_PAT) begin
            pat[loaded] = ltr;
            loaded++;
         end
      end
      nscan = (plen > 20) ? $urandom_range(140, 70) : $urandom_range(3 * plen + 12, 4);
      k = 0;
      while (k < nscan) begin
         r = $urandom_range(39);
         if (r == 0) begin
            send_noise();
         end else if (r == 1) begin
            send_req(sam_pkg::ACT_LOAD, 5'($urandom_range(ALPHA - 1)), 1'b0, '0);
         end else if (r < 6 && loaded > 0) begin
            for (j = loaded - 1; j > 0; j--) begin
               r = $urandom_range(j);
               tmp = pat[j];
               pat[j] = pat[r];
               pat[r] = tmp;
            end
            for (j = 0; j < loaded; j++) send_req(sam_pkg::ACT_SCAN, pat[j], 1'b0, '0);
            k += loaded;
         end else begin
            send_req(sam_pkg::ACT_SCAN, pick_letter(palette, npal), 1'b0, '0);
            k++;
         end
      end
   endtask

   // result side: random stalls and the checker
   always @(posedge clock) begin
      verdict_type exp_v;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= snk_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (window_verdicts.size() == 0) begin
               flag_error($sformatf("unexpected result: match %0d start %0d",
                                    rsp_tuser, rsp_tdata));
            end else begin
               exp_v = window_verdicts.pop_front();
               if (rsp_tuser[0] !== exp_v.match)
                  flag_error($sformatf("match: expected %0d, got %0d",
                                       exp_v.match, rsp_tuser));
               if (rsp_tdata !== exp_v.start)
                  flag_error($sformatf("start_position: expected %0d, got %0d",
                                       exp_v.start, rsp_tdata));
            end
         end
      end
   end

   // watchdog: too long without any item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // pattern "aza" gives windows that are easy to follow by hand
   stim_row_type directed_rows[23] = '{
      '{sam_pkg::ACT_SCAN,  5'd0,  1'b1, '{1'b0, 32'd0}},   // empty pattern right after reset
      '{sam_pkg::ACT_BEGIN, 5'd0,  1'b0, '0},               // unlock loads again
      '{sam_pkg::ACT_LOAD,  5'd31, 1'b0, '0},               // letter outside the alphabet
      '{sam_pkg::ACT_LOAD,  5'd0,  1'b0, '0},
      '{sam_pkg::ACT_LOAD,  5'd25, 1'b0, '0},
      '{sam_pkg::ACT_LOAD,  5'd0,  1'b0, '0},
      '{sam_pkg::ACT_SCAN,  5'd26, 1'b0, '0},
      '{sam_pkg::ACT_SCAN,  5'd25, 1'b1, '{1'b0, 32'd0}},   // window still short
      '{sam_pkg::ACT_SCAN,  5'd0,  1'b1, '{1'b0, 32'd0}},
      '{sam_pkg::ACT_SCAN,  5'd0,  1'b1, '{1'b1, 32'd0}},
      '{sam_pkg::ACT_SCAN,  5'd0,  1'b1, '{1'b0, 32'd0}},
      '{sam_pkg::ACT_SCAN,  5'd25, 1'b1, '{1'b1, 32'd2}},
      '{sam_pkg::ACT_LOAD,  5'd1,  1'b0, '0},               // load after scan is dropped
      '{sam_pkg::ACT_SCAN,  5'd1,  1'b0, '0},
      '{sam_pkg::ACT_SCAN,  5'd31, 1'b0, '0},
      '{sam_pkg::ACT_BEGIN, 5'd0,  1'b0, '0},
      '{sam_pkg::ACT_SCAN,  5'd5,  1'b1, '{1'b0, 32'd0}},   // empty pattern after begin
      '{sam_pkg::ACT_BEGIN, 5'd31, 1'b0, '0},
      '{sam_pkg::ACT_LOAD,  5'd3,  1'b0, '0},
      '{sam_pkg::ACT_SCAN,  5'd3,  1'b1, '{1'b1, 32'd0}},
      '{sam_pkg::ACT_SCAN,  5'd4,  1'b0, '0},
      '{sam_pkg::ACT_SCAN,  5'd3,  1'b1, '{1'b1, 32'd2}},
      '{sam_pkg::ACT_RSVD,  5'd31, 1'b0, '0}
   };

   initial begin
      clear_search();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_req(directed_rows[i].act, directed_rows[i].letter,
                  directed_rows[i].typed, directed_rows[i].verdict);
      while (effective_items < TARGET_ITEMS) begin
         if (effective_items >= (2 * TARGET_ITEMS) / 3) begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end else if (effective_items >= TARGET_ITEMS / 3) begin
            src_idle_pct = 83;
            snk_idle_pct = 21;
         end
         run_search();
      end
      req_tvalid <= 1'b0;
      while (window_verdicts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
